### src/irnd_pkg.sv
// Shared types, constants and the duration helper function of the IR nibble stream decoder.
package irnd_pkg;

  localparam int RESOLUTION = 256;
  localparam int TIME_BITS  = 32;

  localparam int DUR_W   = 24;
  localparam int SUM_W   = 32;
  localparam int CFG_W   = 32;
  localparam int CFG_A_W = 2;
  localparam int MAX_EV  = 3;

  localparam logic [3:0] NIB_ESC      = 4'hF;
  localparam logic [7:0] TIMEOUT_BYTE = 8'hFF;

  localparam logic [DUR_W-1:0] MAX_DUR_RST  = 24'd500000;
  localparam logic [DUR_W-1:0] TMO_DUR_RST  = 24'd65280;
  localparam logic             TMO_EN_RST   = 1'b1;
  localparam logic [31:0]      LONG_GAP_RST = 32'd15000000;

  typedef enum logic [1:0] {
    KindPulse = 2'd0,
    KindSpace = 2'd1,
    KindEnd   = 2'd2
  } kind_e;

  typedef enum logic [CFG_A_W-1:0] {
    CfgMaxDur  = 2'd0,
    CfgTmoDur  = 2'd1,
    CfgTmoEn   = 2'd2,
    CfgLongGap = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DUR_W-1:0] max_dur;
    logic [DUR_W-1:0] tmo_dur;
    logic             tmo_en;
    logic [31:0]      long_gap;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [DUR_W-1:0] dur;
  } event_t;

  typedef struct packed {
    logic [1:0]              cnt;
    event_t [MAX_EV-1:0]     ev;
  } bundle_t;

  function automatic logic [DUR_W-1:0] count_dur(input logic [7:0] count);
    return DUR_W'(count) * DUR_W'(RESOLUTION) + DUR_W'(RESOLUTION / 2);
  endfunction

endpackage

### src/irnd_cfg_regs.sv
// Configuration register file of the IR nibble stream decoder.
module irnd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [irnd_pkg::CFG_A_W-1:0]  cfg_idx_i,
  input  logic [irnd_pkg::CFG_W-1:0]    cfg_data_i,
  output irnd_pkg::cfg_t                cfg_o
);
  import irnd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_dur  <= MAX_DUR_RST;
      cfg_q.tmo_dur  <= TMO_DUR_RST;
      cfg_q.tmo_en   <= TMO_EN_RST;
      cfg_q.long_gap <= LONG_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgMaxDur:  cfg_q.max_dur  <= cfg_data_i[DUR_W-1:0];
        CfgTmoDur:  cfg_q.tmo_dur  <= cfg_data_i[DUR_W-1:0];
        CfgTmoEn:   cfg_q.tmo_en   <= cfg_data_i[0];
        CfgLongGap: cfg_q.long_gap <= cfg_data_i[31:0];
        default:    cfg_q          <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/irnd_decode.sv
// Nibble decoder: phase, idle, sum and start-time state, and the event bundle of one byte.
module irnd_decode #(
  parameter int TimeBits = irnd_pkg::TIME_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       time_us_i,
  input  irnd_pkg::cfg_t    cfg_i,
  output irnd_pkg::bundle_t bundle_o
);
  import irnd_pkg::*;

  localparam int CmpW = (TimeBits > 32) ? TimeBits : 32;

  typedef enum logic [1:0] {
    PhPair      = 2'd0,
    PhFullPulse = 2'd1,
    PhFullSpace = 2'd2,
    PhSkipPulse = 2'd3
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                idle_q;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [TimeBits-1:0] start_q, now;

  logic             pls_en, spc_en, end_en, gap_en, tmo_sel, idle_set, spc_add;
  logic [7:0]       pls_cnt, spc_cnt;
  logic [DUR_W-1:0] pls_dur, spc_dur, pls_out, spc_out, gap_out;
  logic [SUM_W-1:0] sum_base;
  logic [SUM_W+1:0] sum_tot;
  logic [TimeBits-1:0] delta;
  logic [CmpW-1:0]     delta_w, sum_w, gap_diff;
  event_t [3:0]        cand;
  logic   [3:0]        cand_en;
  logic   [1:0]        n;

  assign now = TimeBits'(time_us_i);

  always_comb begin
    phase_d  = phase_q;
    pls_en   = 1'b0;
    spc_en   = 1'b0;
    end_en   = 1'b0;
    tmo_sel  = 1'b0;
    idle_set = 1'b0;
    pls_cnt  = rx_byte_i;
    spc_cnt  = rx_byte_i;
    unique case (phase_q)
      PhPair: begin
        if (rx_byte_i[7:4] == NIB_ESC) begin
          phase_d = PhFullPulse;
        end else begin
          pls_en  = 1'b1;
          pls_cnt = {4'h0, rx_byte_i[7:4]};
          if (rx_byte_i[3:0] == NIB_ESC) begin
            phase_d = PhFullSpace;
          end else begin
            spc_en  = 1'b1;
            spc_cnt = {4'h0, rx_byte_i[3:0]};
          end
        end
      end
      PhFullPulse: begin
        pls_en  = 1'b1;
        phase_d = PhSkipPulse;
      end
      PhFullSpace: begin
        phase_d = PhPair;
        if (rx_byte_i == TIMEOUT_BYTE) begin
          idle_set = 1'b1;
          tmo_sel  = 1'b1;
          spc_en   = cfg_i.tmo_en;
          end_en   = 1'b1;
        end else begin
          spc_en = 1'b1;
        end
      end
      PhSkipPulse: begin
        if (rx_byte_i[3:0] == NIB_ESC) begin
          phase_d = PhFullSpace;
        end else begin
          spc_en  = 1'b1;
          spc_cnt = {4'h0, rx_byte_i[3:0]};
          phase_d = PhPair;
        end
      end
      default: phase_d = PhPair;
    endcase
  end

  assign gap_en  = pls_en & idle_q;
  assign spc_add = spc_en & ~tmo_sel;
  assign pls_dur = count_dur(pls_cnt);
  assign spc_dur = count_dur(spc_cnt);
  assign pls_out = (pls_dur > cfg_i.max_dur) ? cfg_i.max_dur : pls_dur;
  assign spc_out = tmo_sel ? cfg_i.tmo_dur : spc_dur;

  assign sum_base = gap_en ? '0 : sum_q;
  assign sum_tot  = (SUM_W+2)'(sum_base) + (SUM_W+2)'(pls_en ? pls_dur : '0)
                  + (SUM_W+2)'(spc_add ? spc_dur : '0);
  assign sum_d    = (|sum_tot[SUM_W+1:SUM_W]) ? '1 : sum_tot[SUM_W-1:0];

  assign delta    = now - start_q;
  assign delta_w  = CmpW'(delta);
  assign sum_w    = CmpW'(sum_q);
  assign gap_diff = delta_w - sum_w;

  always_comb begin
    if (delta_w > CmpW'(cfg_i.long_gap) || sum_w > delta_w) begin
      gap_out = cfg_i.max_dur;
    end else if (gap_diff > CmpW'(cfg_i.max_dur)) begin
      gap_out = cfg_i.max_dur;
    end else begin
      gap_out = gap_diff[DUR_W-1:0];
    end
  end

  always_comb begin
    cand[0]    = '{kind: KindSpace, dur: gap_out};
    cand[1]    = '{kind: KindPulse, dur: pls_out};
    cand[2]    = '{kind: KindSpace, dur: spc_out};
    cand[3]    = '{kind: KindEnd,   dur: '0};
    cand_en    = {end_en, spc_en, pls_en, gap_en};
    bundle_o   = '0;
    n          = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_en[i] && n < 2'(MAX_EV)) begin
        bundle_o.ev[n] = cand[i];
        n = n + 2'd1;
      end
    end
    bundle_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhPair;
      idle_q  <= 1'b1;
      sum_q   <= '0;
      start_q <= '0;
    end else if (adv_i) begin
      phase_q <= phase_d;
      sum_q   <= sum_d;
      if (gap_en) begin
        idle_q  <= 1'b0;
        start_q <= now;
      end else if (idle_set) begin
        idle_q <= 1'b1;
      end
    end
  end

endmodule

### src/irnd_out.sv
// Result register that holds one byte's events and hands them out one transfer at a time.
module irnd_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  irnd_pkg::bundle_t           bundle_i,
  output logic                        ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [irnd_pkg::DUR_W-1:0]  duration_o,
  output logic                        last_o
);
  import irnd_pkg::*;

  bundle_t    bundle_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       take, last_beat;
  event_t     ev;

  assign take      = valid_q & ~out_stall_i;
  assign last_beat = (idx_q == bundle_q.cnt - 2'd1);
  assign ready_o   = ~valid_q | (take & last_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (take) begin
      if (last_beat) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  assign ev          = bundle_q.ev[idx_q];
  assign out_valid_o = valid_q;
  assign kind_o      = ev.kind;
  assign duration_o  = ev.dur;
  assign last_o      = last_beat;

endmodule

### src/ir_nibble_stream_decoder_top.sv
// Top level of the IR nibble stream decoder: input register, decoder and result register.
//
//  Channel  Direction  Handshake                  Payload
//  in       to block   in_valid_i / in_stall_o    rx_byte_i, time_us_i
//  out      from block out_valid_o / out_stall_i  kind_o, duration_o, last_o
//  cfg      to block   cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A byte is registered, decoded while it waits in the input register and its events are loaded
// into the result register, which delivers one event per cycle while out_stall_i is low. A byte
// has at most three events; the next byte loads in the same cycle that its last event is taken.
// A byte that causes no event only updates the decoder state.
// Reset clears the decoder state and all valid flags; no clearing pass is needed.
// A stalled output holds its event while the next byte waits in the input register.
module ir_nibble_stream_decoder_top #(
  parameter int TimeBits = irnd_pkg::TIME_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic [31:0]                   time_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [irnd_pkg::DUR_W-1:0]    duration_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [irnd_pkg::CFG_A_W-1:0]  cfg_idx_i,
  input  logic [irnd_pkg::CFG_W-1:0]    cfg_data_i
);
  import irnd_pkg::*;

  cfg_t        cfg;
  bundle_t     bundle;
  logic        in_valid_q;
  logic [7:0]  rx_byte_q;
  logic [31:0] time_us_q;
  logic        out_ready, adv, load, in_take;

  assign adv        = in_valid_q & out_ready;
  assign load       = adv & (bundle.cnt != 2'd0);
  assign in_stall_o = in_valid_q & ~adv;
  assign in_take    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      rx_byte_q <= rx_byte_i;
      time_us_q <= time_us_i;
    end
  end

  irnd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  irnd_decode #(
    .TimeBits (TimeBits)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .rx_byte_i (rx_byte_q),
    .time_us_i (time_us_q),
    .cfg_i     (cfg),
    .bundle_o  (bundle)
  );

  irnd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .duration_o  (duration_o),
    .last_o      (last_o)
  );

endmodule

### src/irnd_checker.sv
// Port-level checker of the IR nibble stream decoder and its bind to the top level.
module irnd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    kind_o,
  input logic [irnd_pkg::DUR_W-1:0]    duration_o,
  input logic                          last_o
);
  import irnd_pkg::*;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(duration_o)
                                   && $stable(last_o))
    else $error("Stalled result changed or dropped.");

  a_end_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindEnd |-> duration_o == '0 && last_o)
    else $error("End marker carries a duration or is not the final event of its byte.");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("Events of one byte were not delivered in consecutive transfers.");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("Block is not quiet during reset.");

endmodule

bind ir_nibble_stream_decoder_top irnd_checker u_irnd_checker (.*);

### test/ir_nibble_stream_decoder_top_tb.sv
// Testbench for the IR nibble stream decoder: queued byte driver, event monitor and predictor.
`timescale 1ns / 1ps

module ir_nibble_stream_decoder_top_tb;
  import irnd_pkg::*;

  localparam int ResetCycles  = 10;
  localparam int SettleCycles = 8;
  localparam int StallLimit   = 2000;

  typedef enum logic [1:0] {
    PhPulseSpace  = 2'd0,
    PhFullPulse   = 2'd1,
    PhFullSpace   = 2'd2,
    PhIgnorePulse = 2'd3
  } dec_phase_e;

  typedef struct packed {
    logic [7:0]  rx;
    logic [31:0] t;
  } rx_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [DUR_W-1:0] dur;
    logic             last;
  } ir_event_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid_q = 1'b0;
  logic [7:0]        rx_q       = 8'h00;
  logic [31:0]       t_q        = 32'h0;
  logic              out_stall_q = 1'b0;
  logic              cfg_we_q   = 1'b0;
  logic [CFG_A_W-1:0] cfg_idx_q = CfgMaxDur;
  logic [CFG_W-1:0]  cfg_data_q = '0;

  logic              in_stall_o;
  logic              out_valid_o;
  logic [1:0]        kind_o;
  logic [DUR_W-1:0]  duration_o;
  logic              last_o;

  rx_item_t  rx_bytes_q[$];
  ir_event_t predicted_events[$];
  ir_event_t byte_events[$];
  rx_item_t  drv_item;
  ir_event_t want;

  cfg_t        dec_cfg;
  dec_phase_e  dec_phase;
  logic        dec_idle;
  logic [31:0] dec_sum;
  logic [31:0] dec_start;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          n_errors      = 0;
  int          n_pushed      = 0;
  int          quiet_cycles  = 0;
  logic [31:0] gen_now       = 32'h0;

  ir_nibble_stream_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid_q),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_q),
    .time_us_i  (t_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_q),
    .kind_o     (kind_o),
    .duration_o (duration_o),
    .last_o     (last_o),
    .cfg_we_i   (cfg_we_q),
    .cfg_idx_i  (cfg_idx_q),
    .cfg_data_i (cfg_data_q)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void add_event(input kind_e kind, input logic [DUR_W-1:0] dur);
    ir_event_t ev;
    ev.kind = kind;
    ev.dur  = dur;
    ev.last = 1'b0;
    byte_events.push_back(ev);
  endfunction

  function automatic void add_to_sum(input logic [31:0] dur);
    logic [32:0] total;
    total   = {1'b0, dec_sum} + {1'b0, dur};
    dec_sum = total[32] ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  function automatic logic [31:0] count_to_us(input logic [7:0] count);
    return 32'(count) * 32'(RESOLUTION) + 32'(RESOLUTION / 2);
  endfunction

  function automatic void pulse_event(input logic [7:0] count, input logic [31:0] now);
    logic [31:0] delta;
    logic [31:0] gap;
    logic [31:0] dur;
    if (dec_idle) begin
      delta     = now - dec_start;
      dec_start = now;
      if (delta > dec_cfg.long_gap || dec_sum > delta) begin
        gap = 32'(dec_cfg.max_dur);
      end else begin
        gap = delta - dec_sum;
        if (gap > 32'(dec_cfg.max_dur)) begin
          gap = 32'(dec_cfg.max_dur);
        end
      end
      add_event(KindSpace, gap[DUR_W-1:0]);
      dec_idle = 1'b0;
      dec_sum  = '0;
    end
    dur = count_to_us(count);
    add_to_sum(dur);
    if (dur > 32'(dec_cfg.max_dur)) begin
      dur = 32'(dec_cfg.max_dur);
    end
    add_event(KindPulse, dur[DUR_W-1:0]);
  endfunction

  function automatic void space_event(input logic [7:0] count);
    logic [31:0] dur;
    dur = count_to_us(count);
    add_to_sum(dur);
    add_event(KindSpace, dur[DUR_W-1:0]);
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] rx, input logic [31:0] now);
    byte_events.delete();
    case (dec_phase)
      PhPulseSpace: begin
        if (rx[7:4] == NIB_ESC) begin
          dec_phase = PhFullPulse;
        end else if (rx[3:0] == NIB_ESC) begin
          pulse_event({4'h0, rx[7:4]}, now);
          dec_phase = PhFullSpace;
        end else begin
          pulse_event({4'h0, rx[7:4]}, now);
          space_event({4'h0, rx[3:0]});
        end
      end
      PhFullPulse: begin
        pulse_event(rx, now);
        dec_phase = PhIgnorePulse;
      end
      PhFullSpace: begin
        if (rx == TIMEOUT_BYTE) begin
          dec_idle = 1'b1;
          if (dec_cfg.tmo_en) begin
            add_event(KindSpace, dec_cfg.tmo_dur);
          end
          add_event(KindEnd, '0);
        end else begin
          space_event(rx);
        end
        dec_phase = PhPulseSpace;
      end
      default: begin
        if (rx[3:0] == NIB_ESC) begin
          dec_phase = PhFullSpace;
        end else begin
          space_event({4'h0, rx[3:0]});
          dec_phase = PhPulseSpace;
        end
      end
    endcase
    if (byte_events.size() != 0) begin
      byte_events[byte_events.size() - 1].last = 1'b1;
    end
    foreach (byte_events[i]) begin
      predicted_events.push_back(byte_events[i]);
    end
  endfunction

  function automatic logic [3:0] half_nib();
    return 4'($urandom_range(0, 14));
  endfunction

  function automatic void push_rx(input logic [7:0] rx);
    rx_item_t item;
    item.rx = rx;
    item.t  = gen_now;
    rx_bytes_q.push_back(item);
    n_pushed++;
    gen_now += $urandom_range(0, 6000);
  endfunction

  function automatic void gen_signal();
    int n_tok;
    case ($urandom_range(0, 4))
      0: gen_now = gen_now;
      1: gen_now += $urandom_range(0, 600000);
      2: gen_now += $urandom_range(15000000, 60000000);
      3: gen_now = $urandom();
      default: gen_now += $urandom_range(0, 4000);
    endcase
    n_tok = $urandom_range(1, 8);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        6, 7: begin
          push_rx({NIB_ESC, 4'($urandom_range(0, 15))});
          push_rx(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1) == 1) begin
            push_rx({4'($urandom_range(0, 15)), half_nib()});
          end else begin
            push_rx({4'($urandom_range(0, 15)), NIB_ESC});
            push_rx(8'($urandom_range(0, 254)));
          end
        end
        8, 9: begin
          push_rx({half_nib(), NIB_ESC});
          push_rx(8'($urandom_range(0, 254)));
        end
        default: push_rx({half_nib(), half_nib()});
      endcase
    end
    if ($urandom_range(0, 9) < 8) begin
      push_rx({half_nib(), NIB_ESC});
      push_rx(TIMEOUT_BYTE);
    end
  endfunction

  task automatic random_items(input int n_items);
    int target;
    target = n_pushed + n_items;
    while (n_pushed < target) begin
      if ($urandom_range(0, 9) < 8) begin
        gen_signal();
      end else begin
        repeat ($urandom_range(1, 3)) push_rx(8'($urandom()));
      end
    end
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (rx_bytes_q.size() != 0 || in_valid_q || predicted_events.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_q   <= 1'b1;
    cfg_idx_q  <= idx;
    cfg_data_q <= value;
    case (idx)
      CfgMaxDur: dec_cfg.max_dur = value[DUR_W-1:0];
      CfgTmoDur: dec_cfg.tmo_dur = value[DUR_W-1:0];
      CfgTmoEn:  dec_cfg.tmo_en  = value[0];
      default:   dec_cfg.long_gap = value;
    endcase
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid_q && !in_stall_o) begin
        decode_rx_byte(rx_q, t_q);
      end
      if (!in_valid_q || !in_stall_o) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_item = rx_bytes_q.pop_front();
          in_valid_q <= 1'b1;
          rx_q       <= drv_item.rx;
          t_q        <= drv_item.t;
        end else begin
          in_valid_q <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall_q) begin
        if (predicted_events.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("unexpected event transfer: kind %0d duration %0d last %0d",
                     kind_o, duration_o, last_o);
          end
        end else begin
          want = predicted_events.pop_front();
          if (kind_o !== want.kind || duration_o !== want.dur || last_o !== want.last) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("event mismatch: expected kind %0d duration %0d last %0d, got %0d %0d %0d",
                       want.kind, want.dur, want.last, kind_o, duration_o, last_o);
            end
          end
        end
      end
      out_stall_q <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid_q && !in_stall_o) || (out_valid_o && !out_stall_q)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    dec_cfg.max_dur  = MAX_DUR_RST;
    dec_cfg.tmo_dur  = TMO_DUR_RST;
    dec_cfg.tmo_en   = TMO_EN_RST;
    dec_cfg.long_gap = LONG_GAP_RST;
    dec_phase = PhPulseSpace;
    dec_idle  = 1'b1;
    dec_sum   = '0;
    dec_start = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 68;
    // Every phase of the decoder, the timeout, then gaps: sum above elapsed time,
    // long gap, clamped gap and a gap across the timestamp wrap.
    gen_now = 32'd1000;
    push_rx(8'h00);
    push_rx(8'hEE);
    push_rx(8'h3F);
    push_rx(8'h40);
    push_rx(8'hF5);
    push_rx(8'hFF);
    push_rx(8'h2F);
    push_rx(8'h00);
    push_rx(8'hF0);
    push_rx(8'h10);
    push_rx(8'h07);
    push_rx(8'h5F);
    push_rx(TIMEOUT_BYTE);
    gen_now = 32'd2000;
    push_rx(8'h21);
    push_rx(8'h0F);
    push_rx(TIMEOUT_BYTE);
    gen_now = 32'hFFF5_5160;
    push_rx(8'h11);
    push_rx(8'h0F);
    push_rx(TIMEOUT_BYTE);
    gen_now = 32'hFFFF_0000;
    push_rx(8'h11);
    push_rx(8'h0F);
    push_rx(TIMEOUT_BYTE);
    gen_now = 32'h0003_93E0;
    push_rx(8'h11);
    push_rx(8'h0F);
    push_rx(TIMEOUT_BYTE);
    drain();

    random_items(20);
    drain();
    random_items(20);
    drain();

    write_reg(CfgMaxDur, 32'd1000);
    write_reg(CfgTmoDur, 32'd0);
    write_reg(CfgTmoEn, 32'd0);
    write_reg(CfgLongGap, 32'd100000);
    send_idle_pct = 68;
    recv_idle_pct = 26;
    random_items(50);
    drain();

    write_reg(CfgMaxDur, 32'hFFFF_FFFF);
    write_reg(CfgTmoDur, 32'hFFFF_FFFF);
    write_reg(CfgTmoEn, 32'd3);
    write_reg(CfgLongGap, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(50);
    drain();

    write_reg(CfgMaxDur, 32'd0);
    write_reg(CfgTmoDur, $urandom());
    write_reg(CfgTmoEn, 32'd2);
    write_reg(CfgLongGap, 32'd0);
    random_items(20);
    drain();

    if (predicted_events.size() != 0) begin
      n_errors++;
      $display("%0d expected events never arrived", predicted_events.size());
    end
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
